@@ hw/rtl/serial_owner_ring_tracker_assert.svh @@
// ----------------------------------------------------------------------------
// Serial owner ring tracker assertion macros
// Macros for the concurrent checks in the tracker's datapath.
// ----------------------------------------------------------------------------
`ifndef SERIAL_OWNER_RING_TRACKER_ASSERT_SVH
`define SERIAL_OWNER_RING_TRACKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SORT_ASSERT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tracker check failed");

// Next-cycle implication, disabled while reset is high.
`define SORT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tracker check failed");

`endif

@@ hw/rtl/sort_pkg.sv @@
// ----------------------------------------------------------------------------
// Serial owner ring tracker package
// Shared types and constants for the tracker's controller and datapath.
// ----------------------------------------------------------------------------
package sort_pkg;

   localparam int SERIAL_W    = 32;
   localparam int CLIENT_ID_W = 16;
   localparam int STATUS_W    = 2;

   // Wrapped distances above this value point into the future.
   localparam logic [SERIAL_W-1:0] HALF_RANGE = 32'h7FFF_FFFF;

   typedef enum logic {
      OP_ALLOC    = 1'b0,
      OP_VALIDATE = 1'b1
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_VALID   = 2'd0,
      ST_OLD     = 2'd1,
      ST_INVALID = 2'd2,
      ST_ALLOC   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_PLAN,
      S_CLEAR,
      S_WRITE,
      S_VADDR,
      S_VCMP,
      S_RESULT
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       accept;
      logic       plan;
      logic       clr_step;
      logic       write;
      logic       rd;
      logic       st_load;
      status_type st_code;
      logic       rsp_load;
   } dp_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic clr_none;
      logic clr_last;
      logic val_invalid;
      logic val_old;
      logic val_match;
      logic rsp_free;
   } dp_stat_type;

endpackage

@@ hw/rtl/sort_if.sv @@
// ----------------------------------------------------------------------------
// Serial owner ring tracker channels
// Valid/ready channels for requests, responses and the register write port.
// ----------------------------------------------------------------------------
interface sort_req_if;
   logic                               valid;
   logic                               ready;
   logic                               opcode;
   logic [sort_pkg::SERIAL_W-1:0]      serial;
   logic [sort_pkg::CLIENT_ID_W-1:0]   client_id;

   modport source (output valid, output opcode, output serial, output client_id,
                   input ready);
   modport sink (input valid, input opcode, input serial, input client_id,
                 output ready);
endinterface

interface sort_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [sort_pkg::STATUS_W-1:0]  status;

   modport source (output valid, output status, input ready);
   modport sink (input valid, input status, output ready);
endinterface

interface sort_csr_if;
   logic                           valid;
   logic                           ready;
   logic [sort_pkg::SERIAL_W-1:0]  data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/serial_owner_ring_tracker.sv @@
// Allocate: plan, a clearing pass over the entries between the old and new ring
// end for a gap of two or more (the whole ring for a full wipe), write, result.
// Validate: address, compare and result, skipping compare when the serial is old
// or in the future. One item at a time: a new request waits for the last result
// to reach the response register. Reset: a clearing pass zeroes the ring;
// requests wait until it ends, register writes are taken at any time.
// ----------------------------------------------------------------------------
// Serial owner ring tracker
// Tracks which client owns each recently issued serial and validates
// serials against that record.
// ----------------------------------------------------------------------------
module serial_owner_ring_tracker #(
   parameter int RING_DEPTH  = 4096,
   parameter int CLIENT_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   sort_req_if.sink      req_bus,
   sort_rsp_if.source    rsp_bus,
   sort_csr_if.sink      csr_bus
);

   sort_pkg::dp_cmd_type  cmd;
   sort_pkg::dp_stat_type stat;
   logic                  req_ready;

   // The register write port never stalls.
   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = req_ready;

   sort_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_opcode (req_bus.opcode),
      .req_ready  (req_ready),
      .cmd        (cmd),
      .stat       (stat)
   );

   sort_datapath #(
      .RING_DEPTH  (RING_DEPTH),
      .CLIENT_BITS (CLIENT_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_opcode    (req_bus.opcode),
      .req_serial    (req_bus.serial),
      .req_client_id (req_bus.client_id),
      .csr_write     (csr_bus.valid),
      .csr_data      (csr_bus.data),
      .rsp_ready     (rsp_bus.ready),
      .rsp_valid     (rsp_bus.valid),
      .rsp_status    (rsp_bus.status),
      .cmd           (cmd),
      .stat          (stat)
   );

endmodule

@@ hw/rtl/sort_ctrl.sv @@
// ----------------------------------------------------------------------------
// Serial owner ring tracker controller
// Sequences the reset clearing pass, allocate and validate items, and the
// hand-off of each result beat to the response register.
// ----------------------------------------------------------------------------
module sort_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_opcode,
   output logic                  req_ready,
   output sort_pkg::dp_cmd_type  cmd,
   input  sort_pkg::dp_stat_type stat
);

   sort_pkg::ctrl_state_type state_ff;
   sort_pkg::ctrl_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sort_pkg::S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.st_code  = sort_pkg::ST_ALLOC;
      unique case (state_ff)
         sort_pkg::S_INIT: begin
            // Sweep the whole ring once after reset.
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = sort_pkg::S_IDLE;
            end
         end
         sort_pkg::S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               if (sort_pkg::opcode_type'(req_opcode) == sort_pkg::OP_VALIDATE) begin
                  state_in = sort_pkg::S_VADDR;
               end else begin
                  state_in = sort_pkg::S_PLAN;
               end
            end
         end
         sort_pkg::S_PLAN: begin
            cmd.plan = 1'b1;
            if (stat.clr_none) begin
               state_in = sort_pkg::S_WRITE;
            end else begin
               state_in = sort_pkg::S_CLEAR;
            end
         end
         sort_pkg::S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = sort_pkg::S_WRITE;
            end
         end
         sort_pkg::S_WRITE: begin
            cmd.write   = 1'b1;
            cmd.st_load = 1'b1;
            cmd.st_code = sort_pkg::ST_ALLOC;
            state_in    = sort_pkg::S_RESULT;
         end
         sort_pkg::S_VADDR: begin
            // Future and out-of-window serials never touch the ring.
            if (stat.val_invalid) begin
               cmd.st_load = 1'b1;
               cmd.st_code = sort_pkg::ST_INVALID;
               state_in    = sort_pkg::S_RESULT;
            end else if (stat.val_old) begin
               cmd.st_load = 1'b1;
               cmd.st_code = sort_pkg::ST_OLD;
               state_in    = sort_pkg::S_RESULT;
            end else begin
               cmd.rd   = 1'b1;
               state_in = sort_pkg::S_VCMP;
            end
         end
         sort_pkg::S_VCMP: begin
            cmd.st_load = 1'b1;
            cmd.st_code = stat.val_match ? sort_pkg::ST_VALID : sort_pkg::ST_INVALID;
            state_in    = sort_pkg::S_RESULT;
         end
         sort_pkg::S_RESULT: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = sort_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = sort_pkg::S_INIT;
         end
      endcase
   end

endmodule

@@ hw/rtl/sort_datapath.sv @@
// ----------------------------------------------------------------------------
// Serial owner ring tracker datapath
// Holds the owner ring memory, the window registers, the clearing sweep
// and the response register.
// ----------------------------------------------------------------------------
`include "serial_owner_ring_tracker_assert.svh"

module sort_datapath #(
   parameter int RING_DEPTH  = 4096,
   parameter int CLIENT_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_opcode,
   input  logic [sort_pkg::SERIAL_W-1:0]       req_serial,
   input  logic [sort_pkg::CLIENT_ID_W-1:0]    req_client_id,
   input  logic                                csr_write,
   input  logic [sort_pkg::SERIAL_W-1:0]       csr_data,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [sort_pkg::STATUS_W-1:0]       rsp_status,
   input  sort_pkg::dp_cmd_type                cmd,
   output sort_pkg::dp_stat_type               stat
);

   localparam int IDX_W   = $clog2(RING_DEPTH);
   localparam int CNT_W   = $clog2(RING_DEPTH + 1);
   localparam int OWNER_W = (CLIENT_BITS < sort_pkg::CLIENT_ID_W) ?
                            CLIENT_BITS : sort_pkg::CLIENT_ID_W;
   localparam int SW      = sort_pkg::SERIAL_W;

   localparam logic [CNT_W-1:0] DEPTH_CNT  = CNT_W'(RING_DEPTH);
   localparam logic [SW-1:0]    DEPTH_SER  = SW'(RING_DEPTH);
   localparam logic [IDX_W:0]   DEPTH_IDX1 = (IDX_W + 1)'(RING_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(RING_DEPTH - 1);

   // Owner ring.
   logic [OWNER_W-1:0] ring_mem [RING_DEPTH];

   logic [SW-1:0]        last_ff,      last_in;
   logic [SW-1:0]        diff_ff,      diff_in;
   logic [OWNER_W-1:0]   client_ff,    client_in;
   logic [IDX_W-1:0]     ring_end_ff,  ring_end_in;
   logic [CNT_W-1:0]     held_ff,      held_in;
   logic [IDX_W-1:0]     clr_addr_ff,  clr_addr_in;
   logic [CNT_W-1:0]     clr_left_ff,  clr_left_in;
   logic [OWNER_W-1:0]   mem_q_ff;
   sort_pkg::status_type status_ff,    status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   sort_pkg::status_type rsp_stat_ff,  rsp_stat_in;

   logic                 gap_big;
   logic [CNT_W-1:0]     room;
   logic [CNT_W-1:0]     held_plan;
   logic [IDX_W:0]       end_sum;
   logic [IDX_W-1:0]     end_adv;
   logic [IDX_W-1:0]     end_plus1;
   logic [IDX_W-1:0]     clr_addr_step;
   logic [IDX_W:0]       back;
   logic [IDX_W:0]       back_wrap;
   logic [IDX_W-1:0]     rd_idx;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [OWNER_W-1:0]   wr_data;

   // Allocate planning from the latched serial gap.
   always_comb begin
      gap_big   = diff_ff >= DEPTH_SER;
      room      = DEPTH_CNT - held_ff;
      held_plan = (diff_ff >= SW'(room)) ? DEPTH_CNT : held_ff + diff_ff[CNT_W-1:0];
      end_sum   = {1'b0, ring_end_ff} + {1'b0, diff_ff[IDX_W-1:0]};
      end_adv   = (end_sum >= DEPTH_IDX1) ? end_sum[IDX_W-1:0] - DEPTH_IDX1[IDX_W-1:0] :
                                            end_sum[IDX_W-1:0];
      end_plus1 = (ring_end_ff == LAST_IDX) ? '0 : ring_end_ff + 1'b1;
      clr_addr_step = (clr_addr_ff == LAST_IDX) ? '0 : clr_addr_ff + 1'b1;
   end

   // Validate address: step back from the ring end, wrapping below zero.
   always_comb begin
      back      = {1'b0, ring_end_ff} - {1'b0, diff_ff[IDX_W-1:0]};
      back_wrap = back + DEPTH_IDX1;
      rd_idx    = back[IDX_W] ? back_wrap[IDX_W-1:0] : back[IDX_W-1:0];
   end

   // Status toward the controller.
   always_comb begin
      stat.clr_none    = !gap_big && (diff_ff <= SW'(1));
      stat.clr_last    = clr_left_ff == CNT_W'(1);
      stat.val_invalid = diff_ff > sort_pkg::HALF_RANGE;
      stat.val_old     = diff_ff >= SW'(held_ff);
      stat.val_match   = mem_q_ff == client_ff;
      stat.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   // Next values of the window registers and the sweep.
   always_comb begin
      last_in     = last_ff;
      diff_in     = diff_ff;
      client_in   = client_ff;
      ring_end_in = ring_end_ff;
      held_in     = held_ff;
      clr_addr_in = clr_addr_ff;
      clr_left_in = clr_left_ff;
      if (csr_write) begin
         last_in = csr_data;
      end
      if (cmd.accept) begin
         client_in = req_client_id[OWNER_W-1:0];
         if (sort_pkg::opcode_type'(req_opcode) == sort_pkg::OP_VALIDATE) begin
            diff_in = last_ff - req_serial;
         end else begin
            diff_in = req_serial - last_ff;
            last_in = req_serial;
         end
      end
      if (cmd.plan) begin
         held_in = held_plan;
         if (gap_big) begin
            // A gap of a full ring or more wipes everything.
            ring_end_in = '0;
            clr_addr_in = '0;
            clr_left_in = DEPTH_CNT;
         end else begin
            ring_end_in = end_adv;
            clr_addr_in = end_plus1;
            clr_left_in = diff_ff[CNT_W-1:0] - 1'b1;
         end
      end
      if (cmd.clr_step) begin
         clr_addr_in = clr_addr_step;
         clr_left_in = clr_left_ff - 1'b1;
      end
   end

   // Next values of the result and response registers.
   always_comb begin
      status_in    = cmd.st_load ? cmd.st_code : status_ff;
      rsp_stat_in  = cmd.rsp_load ? status_ff : rsp_stat_ff;
      rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & ~rsp_ready);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff      <= '0;
         ring_end_ff  <= '0;
         held_ff      <= '0;
         clr_addr_ff  <= '0;
         clr_left_ff  <= DEPTH_CNT;
         rsp_valid_ff <= 1'b0;
      end else begin
         last_ff      <= last_in;
         ring_end_ff  <= ring_end_in;
         held_ff      <= held_in;
         clr_addr_ff  <= clr_addr_in;
         clr_left_ff  <= clr_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      diff_ff     <= diff_in;
      client_ff   <= client_in;
      status_ff   <= status_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   // Single-port ring: a clear or owner write, or one registered read.
   always_comb begin
      wr_en   = cmd.clr_step | cmd.write;
      wr_addr = cmd.write ? ring_end_ff : clr_addr_ff;
      wr_data = cmd.write ? client_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd) begin
         mem_q_ff <= ring_mem[rd_idx];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_stat_ff;

   // Checks.
   `SORT_ASSERT(a_clear_has_work, clock, reset, cmd.clr_step, clr_left_ff != '0)
   `SORT_ASSERT(a_read_in_window, clock, reset, cmd.rd, diff_ff < SW'(held_ff))
   `SORT_ASSERT_NEXT(a_wipe_resets_end, clock, reset, cmd.plan && gap_big, ring_end_ff == '0 && held_ff == DEPTH_CNT)
   `SORT_ASSERT_NEXT(a_held_grows, clock, reset, 1'b1, held_ff >= $past(held_ff))

endmodule

@@ tb/tb_serial_owner_ring_tracker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Serial owner ring tracker testbench
// Drives allocate and validate beats into the tracker and checks every
// response status against a cycle-free model of the owner ring or a table
// row's status. A short table of hand-picked beats comes first, then several
// random phases, each opened by a fresh start serial. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_serial_owner_ring_tracker;

   localparam int unsigned DEPTH       = 4096;
   localparam int          HOLD_CYCLES = 400;
   localparam int          STALL_LIMIT = 20000;
   localparam int          PHASE_ITEMS = 275;

   // One row of the hand-written table. Rows with known set carry their
   // status; the others take the model's answer.
   typedef struct packed {
      sort_pkg::opcode_type op;
      logic [31:0]          serial;
      logic [15:0]          client;
      logic                 known;
      sort_pkg::status_type status;
   } probe_row_type;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_BUSY,
      RX_SPARSE,
      RX_PERIODIC
   } rx_mode_type;

   logic clock = 1'b0;
   logic reset;
   // Toggled by the sender to ask the receiver for one long hold-off.
   logic hold_off_req;

   sort_req_if req_bus ();
   sort_rsp_if rsp_bus ();
   sort_csr_if csr_bus ();

   serial_owner_ring_tracker dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Model of the ring and its window.
   logic [15:0]  owner_ring [DEPTH];
   int unsigned  ring_end;
   int unsigned  held_count;
   logic [31:0]  last_issued;

   sort_pkg::status_type status_q [$];
   int           errors = 0;
   int           burst_left = 0;
   int           idle_cycles = 0;

   // The start serial is loaded into last_issued at once (reset value 0).
   probe_row_type probe_table [25] = '{
      '{sort_pkg::OP_VALIDATE, 32'hFFFF_FFF0, 16'h0000, 1'b1, sort_pkg::ST_OLD},
      '{sort_pkg::OP_VALIDATE, 32'hFFFF_FFFF, 16'h0005, 1'b1, sort_pkg::ST_INVALID},
      '{sort_pkg::OP_ALLOC,    32'hFFFF_FFF0, 16'h0007, 1'b1, sort_pkg::ST_ALLOC},
      '{sort_pkg::OP_ALLOC,    32'hFFFF_FFF1, 16'hFFFF, 1'b1, sort_pkg::ST_ALLOC},
      '{sort_pkg::OP_VALIDATE, 32'hFFFF_FFF1, 16'hFFFF, 1'b0, sort_pkg::ST_VALID},
      '{sort_pkg::OP_ALLOC,    32'hFFFF_FFF1, 16'h1234, 1'b1, sort_pkg::ST_ALLOC},
      '{sort_pkg::OP_VALIDATE, 32'hFFFF_FFF1, 16'hFFFF, 1'b0, sort_pkg::ST_VALID},
      '{sort_pkg::OP_VALIDATE, 32'hFFFF_FFF1, 16'h1234, 1'b0, sort_pkg::ST_VALID},
      '{sort_pkg::OP_ALLOC,    32'h0000_0005, 16'h0001, 1'b1, sort_pkg::ST_ALLOC},
      '{sort_pkg::OP_VALIDATE, 32'h0000_0000, 16'h0000, 1'b0, sort_pkg::ST_VALID},
      '{sort_pkg::OP_VALIDATE, 32'hFFFF_FFF1, 16'h1234, 1'b0, sort_pkg::ST_VALID},
      '{sort_pkg::OP_VALIDATE, 32'hFFFF_FFF0, 16'h0007, 1'b0, sort_pkg::ST_VALID},
      '{sort_pkg::OP_VALIDATE, 32'h0000_0006, 16'h0001, 1'b1, sort_pkg::ST_INVALID},
      '{sort_pkg::OP_VALIDATE, 32'h8000_0006, 16'h0001, 1'b1, sort_pkg::ST_OLD},
      '{sort_pkg::OP_VALIDATE, 32'h8000_0005, 16'h0001, 1'b1, sort_pkg::ST_INVALID},
      '{sort_pkg::OP_ALLOC,    32'h0000_1004, 16'h0002, 1'b1, sort_pkg::ST_ALLOC},
      '{sort_pkg::OP_VALIDATE, 32'h0000_0005, 16'h0001, 1'b0, sort_pkg::ST_VALID},
      '{sort_pkg::OP_VALIDATE, 32'h0000_0004, 16'h0000, 1'b1, sort_pkg::ST_OLD},
      '{sort_pkg::OP_ALLOC,    32'h0000_2004, 16'h0003, 1'b1, sort_pkg::ST_ALLOC},
      '{sort_pkg::OP_VALIDATE, 32'h0000_2004, 16'h0003, 1'b0, sort_pkg::ST_VALID},
      '{sort_pkg::OP_VALIDATE, 32'h0000_2003, 16'h0000, 1'b0, sort_pkg::ST_VALID},
      '{sort_pkg::OP_VALIDATE, 32'h0000_2003, 16'h0002, 1'b0, sort_pkg::ST_VALID},
      '{sort_pkg::OP_ALLOC,    32'h0000_2000, 16'h0004, 1'b1, sort_pkg::ST_ALLOC},
      '{sort_pkg::OP_VALIDATE, 32'h0000_2000, 16'h0004, 1'b0, sort_pkg::ST_VALID},
      '{sort_pkg::OP_VALIDATE, 32'h0000_2001, 16'h0004, 1'b1, sort_pkg::ST_INVALID}
   };

   always #5 clock = ~clock;

   // Applies one beat to the ring model and returns the status it yields.
   function automatic sort_pkg::status_type track_item(sort_pkg::opcode_type op,
                                                       logic [31:0] ser,
                                                       logic [15:0] cid);
      logic [31:0] span;
      int unsigned k;
      if (op == sort_pkg::OP_ALLOC) begin
         // The gap wraps, so a serial behind the last one is a huge gap.
         span = ser - last_issued;
         if (span >= DEPTH - held_count)
            held_count = DEPTH;
         else
            held_count += span;
         if (span >= DEPTH) begin
            for (k = 0; k < DEPTH; k++)
               owner_ring[k] = '0;
            owner_ring[0] = cid;
            ring_end = 0;
         end else begin
            // Entries strictly between the old and new end are cleared.
            for (k = 1; k < span; k++)
               owner_ring[(ring_end + k) % DEPTH] = '0;
            ring_end = (ring_end + span) % DEPTH;
            owner_ring[ring_end] = cid;
         end
         last_issued = ser;
         return sort_pkg::ST_ALLOC;
      end
      span = last_issued - ser;
      if (span > sort_pkg::HALF_RANGE)
         return sort_pkg::ST_INVALID;
      if (span >= held_count)
         return sort_pkg::ST_OLD;
      return (owner_ring[(ring_end + DEPTH - span) % DEPTH] == cid) ?
             sort_pkg::ST_VALID : sort_pkg::ST_INVALID;
   endfunction

   // Picks a client id, leaning on a few ids so that owners repeat.
   function automatic logic [15:0] pick_client();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return 16'h0000;
      if (r == 1)
         return 16'hFFFF;
      if (r < 6)
         return 16'($urandom_range(1, 4));
      return 16'($urandom);
   endfunction

   // Builds a random beat from the current model state. Most allocations
   // advance by one and most checks land inside the held window.
   task automatic make_item(output sort_pkg::opcode_type op, output logic [31:0] ser,
                            output logic [15:0] cid);
      int unsigned roll;
      logic [31:0] back_dist;
      roll = $urandom_range(0, 99);
      cid = pick_client();
      if ($urandom_range(0, 99) < 45) begin
         op = sort_pkg::OP_ALLOC;
         if (roll < 8)
            ser = last_issued;
         else if (roll < 70)
            ser = last_issued + 1;
         else if (roll < 88)
            ser = last_issued + $urandom_range(2, 16);
         else if (roll < 92)
            ser = last_issued + ($urandom_range(0, 1) ? DEPTH - 1
                                                      : $urandom_range(17, DEPTH - 1));
         else if (roll < 96)
            ser = last_issued + $urandom_range(32'hFFFF_FFFF, DEPTH);
         else
            ser = last_issued - $urandom_range(1, 100);
      end else begin
         op = sort_pkg::OP_VALIDATE;
         if (roll < 60) begin
            if (held_count == 0)
               back_dist = 0;
            else if ($urandom_range(0, 1))
               back_dist = $urandom_range(0, (held_count > 9) ? 8 : held_count - 1);
            else
               back_dist = $urandom_range(0, held_count - 1);
            // Ask for the recorded owner most of the time.
            if (back_dist < DEPTH && $urandom_range(0, 9) < 6)
               cid = owner_ring[(ring_end + DEPTH - back_dist) % DEPTH];
         end else if (roll < 70)
            back_dist = (held_count == 0 || $urandom_range(0, 1)) ? held_count
                                                                   : held_count - 1;
         else if (roll < 80)
            back_dist = $urandom_range(held_count, 32'h7FFF_FFFF);
         else if (roll < 90)
            back_dist = $urandom_range(32'h8000_0000, 32'hFFFF_FFFF);
         else
            back_dist = $urandom;
         ser = last_issued - back_dist;
      end
   endtask

   // Offers one request beat and records its expected status when taken.
   task automatic send_item(input sort_pkg::opcode_type op, input logic [31:0] ser,
                            input logic [15:0] cid, input logic known,
                            input sort_pkg::status_type known_st);
      int unsigned pause;
      sort_pkg::status_type st;
      if (burst_left == 0) begin
         pause = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (pause > 0) begin
            req_bus.valid <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_bus.valid     <= 1'b1;
      req_bus.opcode    <= op;
      req_bus.serial    <= ser;
      req_bus.client_id <= cid;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      st = track_item(op, ser, cid);
      status_q.push_back(known ? known_st : st);
      burst_left--;
   endtask

   // Drops the request and waits until every response has come back.
   task automatic drain();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (status_q.size() != 0)
         @(posedge clock);
   endtask

   // Writes the start serial; the model reloads last_issued on the beat.
   task automatic write_start_serial(input logic [31:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      last_issued = value;
      csr_bus.valid <= 1'b0;
   endtask

   // Main sequence: reset, table, then random phases.
   initial begin
      sort_pkg::opcode_type op;
      logic [31:0]  ser;
      logic [15:0]  cid;
      logic [31:0]  start_values [4];
      int           p;
      int           n;
      start_values = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 32'h0};
      start_values[3] = $urandom;
      for (n = 0; n < DEPTH; n++)
         owner_ring[n] = '0;
      ring_end    = 0;
      held_count  = 0;
      last_issued = '0;

      reset             <= 1'b1;
      hold_off_req      <= 1'b0;
      req_bus.valid     <= 1'b0;
      req_bus.opcode    <= sort_pkg::OP_ALLOC;
      req_bus.serial    <= '0;
      req_bus.client_id <= '0;
      csr_bus.valid     <= 1'b0;
      csr_bus.data      <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      write_start_serial(32'hFFFF_FFF0);
      foreach (probe_table[i])
         send_item(probe_table[i].op, probe_table[i].serial, probe_table[i].client,
                   probe_table[i].known, probe_table[i].status);
      drain();

      for (p = 0; p < 4; p++) begin
         write_start_serial(start_values[p]);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            // Once, let the response side sit still while requests are held off.
            if (p == 1 && n == 40)
               hold_off_req <= ~hold_off_req;
            make_item(op, ser, cid);
            send_item(op, ser, cid, 1'b0, sort_pkg::ST_VALID);
         end
         drain();
      end

      repeat (20) @(posedge clock);
      if (errors == 0 && status_q.size() == 0)
         $display("** serial_owner_ring_tracker: PASSED **");
      else
         $display("** serial_owner_ring_tracker: FAILED **");
      $finish;
   end

   // Response side: changing stall patterns, plus one long hold-off.
   initial begin
      rx_mode_type mode;
      int          mode_left;
      int          tick;
      logic        hold_seen;
      mode = RX_OPEN;
      mode_left = 0;
      tick = 0;
      hold_seen = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_off_req != hold_seen) begin
            hold_seen = hold_off_req;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               mode = rx_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(50, 200);
            end
            mode_left--;
            case (mode)
               RX_OPEN:     rsp_bus.ready <= 1'b1;
               RX_BUSY:     rsp_bus.ready <= ($urandom_range(0, 9) < 7);
               RX_SPARSE:   rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               RX_PERIODIC: rsp_bus.ready <= (tick % 3 == 0);
            endcase
         end
      end
   end

   // Compares each response beat with the oldest expected status.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (status_q.size() == 0) begin
            $display("%0t: unexpected response, status %0d", $time, rsp_bus.status);
            errors++;
         end else if (rsp_bus.status !== status_q[0]) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, status_q[0], rsp_bus.status);
            errors++;
            void'(status_q.pop_front());
         end else begin
            void'(status_q.pop_front());
         end
      end
   end

   // Ends the run if no beat moves on any channel for too long.
   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) ||
          (csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
         $display("** serial_owner_ring_tracker: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/sort_pkg.sv
hw/rtl/sort_if.sv
hw/rtl/sort_ctrl.sv
hw/rtl/sort_datapath.sv
hw/rtl/serial_owner_ring_tracker.sv
tb/tb_serial_owner_ring_tracker.sv
